FILE: rtl/core/lcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_pkg
// Shared widths, defaults and operation codes of the cache tag directory.
// ----------------------------------------------------------------------------
package lcd_pkg;

  localparam int NUM_WAYS_DEF  = 4;
  localparam int NUM_SLOTS_DEF = 32;

  localparam int OP_W        = 2;
  localparam int SLOT_W      = 5;
  localparam int WAY_FIELD_W = 2;
  localparam int STAMP_W     = 32;

  typedef enum logic [OP_W-1:0] {
    OP_FETCH      = 2'd0,
    OP_PUT        = 2'd1,
    OP_INVALIDATE = 2'd2
  } op_t;

  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [STAMP_W-1:0] stamp_t;

endpackage

FILE: rtl/core/lcd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_req_if / lcd_rsp_if
// Valid/ready channels for directory requests and their results.
// ----------------------------------------------------------------------------
interface lcd_req_if;
  logic                       valid;
  logic                       ready;
  logic [lcd_pkg::OP_W-1:0]   operation;
  logic [lcd_pkg::SLOT_W-1:0] slot_number;
  logic                       fill_ok;

  modport source (output valid, operation, slot_number, fill_ok, input ready);
  modport sink   (input valid, operation, slot_number, fill_ok, output ready);
endinterface

interface lcd_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic [lcd_pkg::WAY_FIELD_W-1:0] way_index;
  logic                            success;

  modport source (output valid, hit, way_index, success, input ready);
  modport sink   (input valid, hit, way_index, success, output ready);
endinterface

FILE: rtl/core/lcd_victim_sel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_victim_sel
// Replacement choice: the first invalid way above way 0, otherwise the way
// with the oldest stamp, found by a comparison tree where the lower way wins.
// ----------------------------------------------------------------------------
module lcd_victim_sel #(
  parameter int NUM_WAYS = lcd_pkg::NUM_WAYS_DEF
) (
  input  logic                        way_valid [NUM_WAYS],
  input  lcd_pkg::stamp_t             way_stamp [NUM_WAYS],
  output logic [$clog2(NUM_WAYS)-1:0] victim
);

  localparam int WAY_W = $clog2(NUM_WAYS);
  localparam int P2    = 1 << WAY_W;

  logic                 leaf_has   [P2];
  logic [WAY_W-1:0]     leaf_idx   [P2];
  lcd_pkg::stamp_t      leaf_stamp [P2];

  logic                 node_has   [2*P2];
  logic [WAY_W-1:0]     node_idx   [2*P2];
  lcd_pkg::stamp_t      node_stamp [2*P2];

  logic                 inv_found;
  logic [WAY_W-1:0]     inv_idx;

  for (genvar i = 0; i < P2; i++) begin : g_leaf
    if (i < NUM_WAYS) begin : g_real
      assign leaf_has[i]   = 1'b1;
      assign leaf_stamp[i] = way_stamp[i];
    end else begin : g_pad
      assign leaf_has[i]   = 1'b0;
      assign leaf_stamp[i] = '0;
    end
    assign leaf_idx[i] = WAY_W'(i);
  end

  always_comb begin
    for (int n = 0; n < 2*P2; n++) begin
      node_has[n]   = 1'b0;
      node_idx[n]   = '0;
      node_stamp[n] = '0;
    end
    for (int i = 0; i < P2; i++) begin
      node_has[P2+i]   = leaf_has[i];
      node_idx[P2+i]   = leaf_idx[i];
      node_stamp[P2+i] = leaf_stamp[i];
    end
    for (int k = P2 - 1; k >= 1; k--) begin
      if (!node_has[2*k] ||
          (node_has[2*k+1] && (node_stamp[2*k+1] < node_stamp[2*k]))) begin
        node_has[k]   = node_has[2*k+1];
        node_idx[k]   = node_idx[2*k+1];
        node_stamp[k] = node_stamp[2*k+1];
      end else begin
        node_has[k]   = node_has[2*k];
        node_idx[k]   = node_idx[2*k];
        node_stamp[k] = node_stamp[2*k];
      end
    end
  end

  always_comb begin
    inv_found = 1'b0;
    inv_idx   = '0;
    for (int w = NUM_WAYS - 1; w >= 1; w--) begin
      if (!way_valid[w]) begin
        inv_found = 1'b1;
        inv_idx   = WAY_W'(w);
      end
    end
  end

  assign victim = inv_found ? inv_idx : node_idx[1];

endmodule

FILE: rtl/core/lru_cache_directory.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_cache_directory
// Tag directory of a small fully associative cache with LRU replacement.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel (fetch, put or invalidate of a slot) and
// each one yields exactly one result on the rsp channel (hit, way, success).
// A transfer happens on a rising edge with valid and ready both high.
// A request is first captured in an input register. From there the tag
// compare, the victim tree and the state update run in one pass and the
// result is written to the output register. One request per cycle is
// sustained while the receiver takes results; the rate is set by the tag
// compare and stamp comparison tree running in one pass.
// When the receiver stalls, the result stays in the output register and the
// input register still takes one more request; req.ready drops only when both
// registers are full. Reset clears all valid bits, the stamps, the stamp
// counter and the valid flags of both pipeline registers.
// ----------------------------------------------------------------------------
module lru_cache_directory #(
  parameter int NUM_WAYS  = lcd_pkg::NUM_WAYS_DEF,
  parameter int NUM_SLOTS = lcd_pkg::NUM_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  lcd_req_if.sink   req,
  lcd_rsp_if.source rsp
);

  localparam int WAY_W = $clog2(NUM_WAYS);

  logic                            in_vld;
  logic [lcd_pkg::OP_W-1:0]        in_op;
  lcd_pkg::slot_t                  in_slot;
  logic                            in_fill;

  logic                            out_vld;
  logic                            out_hit;
  logic [lcd_pkg::WAY_FIELD_W-1:0] out_way;
  logic                            out_ok;

  logic                            way_valid      [NUM_WAYS];
  lcd_pkg::slot_t                  way_tag        [NUM_WAYS];
  lcd_pkg::stamp_t                 way_stamp      [NUM_WAYS];
  lcd_pkg::stamp_t                 stamp_counter;

  logic                            way_valid_next [NUM_WAYS];
  lcd_pkg::slot_t                  way_tag_next   [NUM_WAYS];
  lcd_pkg::stamp_t                 way_stamp_next [NUM_WAYS];
  lcd_pkg::stamp_t                 stamp_counter_next;

  logic                            fire;
  logic                            in_range;
  logic                            hit_found;
  logic [WAY_W-1:0]                hit_way;
  logic [WAY_W-1:0]                victim;
  lcd_pkg::stamp_t                 stamp_inc;

  logic                            res_hit;
  logic [WAY_W-1:0]                res_way;
  logic                            res_ok;
  logic [WAY_W+1:0]                res_way_wide;

  assign fire      = in_vld && (!out_vld || rsp.ready);
  assign req.ready = !in_vld || fire;
  assign in_range  = {1'b0, in_slot} < (lcd_pkg::SLOT_W + 1)'(NUM_SLOTS);
  assign stamp_inc = stamp_counter + 1'b1;

  always_comb begin
    hit_found = 1'b0;
    hit_way   = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (way_valid[w] && (way_tag[w] == in_slot)) begin
        hit_found = 1'b1;
        hit_way   = WAY_W'(w);
      end
    end
  end

  lcd_victim_sel #(
    .NUM_WAYS (NUM_WAYS)
  ) u_victim (
    .way_valid (way_valid),
    .way_stamp (way_stamp),
    .victim    (victim)
  );

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      way_valid_next[w] = way_valid[w];
      way_tag_next[w]   = way_tag[w];
      way_stamp_next[w] = way_stamp[w];
    end
    stamp_counter_next = stamp_counter;
    res_hit = 1'b0;
    res_way = '0;
    res_ok  = 1'b0;

    if (in_range) begin
      case (in_op)
        lcd_pkg::OP_FETCH: begin
          if (hit_found) begin
            way_stamp_next[hit_way] = stamp_inc;
            stamp_counter_next      = stamp_inc;
            res_hit = 1'b1;
            res_way = hit_way;
            res_ok  = 1'b1;
          end else begin
            res_way = victim;
            if (in_fill) begin
              way_tag_next[victim]   = in_slot;
              way_valid_next[victim] = 1'b1;
              way_stamp_next[victim] = stamp_inc;
              stamp_counter_next     = stamp_inc;
              res_ok = 1'b1;
            end else begin
              way_valid_next[victim] = 1'b0;
            end
          end
        end
        lcd_pkg::OP_PUT: begin
          res_hit = hit_found;
          res_way = hit_found ? hit_way : victim;
          res_ok  = 1'b1;
          way_tag_next[res_way]   = in_slot;
          way_valid_next[res_way] = 1'b1;
          way_stamp_next[res_way] = stamp_inc;
          stamp_counter_next      = stamp_inc;
        end
        lcd_pkg::OP_INVALIDATE: begin
          if (hit_found) begin
            way_valid_next[hit_way] = 1'b0;
            res_hit = 1'b1;
            res_way = hit_way;
            res_ok  = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign res_way_wide = {2'b00, res_way};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (req.ready) begin
      in_vld <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_op   <= req.operation;
      in_slot <= req.slot_number;
      in_fill <= req.fill_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (fire) begin
      out_vld <= 1'b1;
    end else if (rsp.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_hit <= res_hit;
      out_way <= res_way_wide[lcd_pkg::WAY_FIELD_W-1:0];
      out_ok  <= res_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        way_valid[w] <= 1'b0;
        way_stamp[w] <= '0;
      end
      stamp_counter <= '0;
    end else if (fire) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        way_valid[w] <= way_valid_next[w];
        way_stamp[w] <= way_stamp_next[w];
      end
      stamp_counter <= stamp_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        way_tag[w] <= way_tag_next[w];
      end
    end
  end

  assign rsp.valid     = out_vld;
  assign rsp.hit       = out_hit;
  assign rsp.way_index = out_way;
  assign rsp.success   = out_ok;

endmodule

FILE: rtl/core/lcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_port_checks
// Port-level checks of the cache tag directory, bound to the top level.
// ----------------------------------------------------------------------------
module lcd_port_checks (
  input logic                            clk,
  input logic                            rst,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input logic                            rsp_hit,
  input logic [lcd_pkg::WAY_FIELD_W-1:0] rsp_way_index,
  input logic                            rsp_success
);

  // No result may be offered in the cycle after reset.
  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result offered right after reset");

  // A hit always completes the operation.
  a_hit_success: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_hit) |-> rsp_success)
    else $error("hit reported without success");

  a_stall_valid: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid)
    else $error("stalled result withdrawn");

  a_stall_payload: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      ($stable(rsp_hit) && $stable(rsp_way_index) && $stable(rsp_success)))
    else $error("stalled result changed");

endmodule

bind lru_cache_directory lcd_port_checks u_lcd_port_checks (
  .clk           (clk),
  .rst           (rst),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_hit       (rsp.hit),
  .rsp_way_index (rsp.way_index),
  .rsp_success   (rsp.success)
);

FILE: tb/lcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_checker
// Watches the request and result channels of the cache tag directory, keeps
// its own copy of the valid bits, tags, use stamps and stamp counter, works
// out the result of every accepted request and compares each result transfer
// field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module lcd_checker #(
  parameter int NUM_WAYS  = lcd_pkg::NUM_WAYS_DEF,
  parameter int NUM_SLOTS = lcd_pkg::NUM_SLOTS_DEF
) (
  input  logic clk,
  input  logic rst,
  lcd_req_if   req,
  lcd_rsp_if   rsp,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic                            hit;
    logic [lcd_pkg::WAY_FIELD_W-1:0] way_index;
    logic                            success;
  } dir_result_t;

  logic            way_valid [NUM_WAYS];
  lcd_pkg::slot_t  way_tag   [NUM_WAYS];
  lcd_pkg::stamp_t way_stamp [NUM_WAYS];
  lcd_pkg::stamp_t stamp_counter;
  dir_result_t     expected_results [$];

  function automatic int pick_victim();
    int best;
    best = 0;
    for (int w = 1; w < NUM_WAYS; w++) begin
      if (!way_valid[w]) return w;
      if (way_stamp[w] < way_stamp[best]) best = w;
    end
    return best;
  endfunction

  function automatic void refresh_stamp(int w);
    stamp_counter = stamp_counter + 1'b1;
    way_stamp[w]  = stamp_counter;
  endfunction

  function automatic dir_result_t predict_directory(logic [lcd_pkg::OP_W-1:0] op,
                                                    lcd_pkg::slot_t slot,
                                                    logic fill);
    dir_result_t r;
    int          w;
    r = '0;
    w = -1;
    if (int'(slot) < NUM_SLOTS) begin
      for (int i = NUM_WAYS - 1; i >= 0; i--) begin
        if (way_valid[i] && way_tag[i] == slot) w = i;
      end
      case (op)
        lcd_pkg::OP_FETCH: begin
          if (w >= 0) begin
            refresh_stamp(w);
            r.hit     = 1'b1;
            r.success = 1'b1;
          end else begin
            w = pick_victim();
            if (fill) begin
              way_tag[w]   = slot;
              way_valid[w] = 1'b1;
              refresh_stamp(w);
              r.success = 1'b1;
            end else begin
              way_valid[w] = 1'b0;
            end
          end
          r.way_index = w[lcd_pkg::WAY_FIELD_W-1:0];
        end
        lcd_pkg::OP_PUT: begin
          if (w >= 0) begin
            r.hit = 1'b1;
          end else begin
            w = pick_victim();
          end
          way_tag[w]   = slot;
          way_valid[w] = 1'b1;
          refresh_stamp(w);
          r.way_index = w[lcd_pkg::WAY_FIELD_W-1:0];
          r.success   = 1'b1;
        end
        lcd_pkg::OP_INVALIDATE: begin
          if (w >= 0) begin
            way_valid[w] = 1'b0;
            r.hit        = 1'b1;
            r.way_index  = w[lcd_pkg::WAY_FIELD_W-1:0];
            r.success    = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    dir_result_t exp_r;
    if (rst) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        way_valid[w] = 1'b0;
        way_tag[w]   = '0;
        way_stamp[w] = '0;
      end
      stamp_counter = '0;
      expected_results.delete();
    end else begin
      if (req.valid && req.ready) begin
        expected_results.push_back(predict_directory(req.operation, req.slot_number,
                                                     req.fill_ok));
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no request outstanding");
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (rsp.hit !== exp_r.hit) begin
            $error("hit mismatch: expected %0d, actual %0d", exp_r.hit, rsp.hit);
            fail_count++;
          end
          if (rsp.way_index !== exp_r.way_index) begin
            $error("way_index mismatch: expected %0d, actual %0d", exp_r.way_index,
                   rsp.way_index);
            fail_count++;
          end
          if (rsp.success !== exp_r.success) begin
            $error("success mismatch: expected %0d, actual %0d", exp_r.success,
                   rsp.success);
            fail_count++;
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Top level for the cache tag directory. Drives a directed sequence of fetch,
// put and invalidate requests covering fills, failed fills, hits, evictions
// and ignored codes, then random requests over a small slot range so that
// hits and LRU evictions are frequent. Both channels idle in random bursts
// except in the final stretch. The checker beside the block judges results.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [lcd_pkg::OP_W-1:0] OP_UNUSED   = 2'd3;
  localparam int                       RAND_ITEMS  = 500;
  localparam int                       QUIET_ITEMS = 100;

  logic clk = 1'b0;
  logic rst;
  bit   quiet;
  int   fail_count;
  int   pending;
  int   guard;

  lcd_req_if req ();
  lcd_rsp_if rsp ();

  lru_cache_directory dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  lcd_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic send_request(logic [lcd_pkg::OP_W-1:0] op, lcd_pkg::slot_t slot,
                              logic fill);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.operation   <= op;
    req.slot_number <= slot;
    req.fill_ok     <= fill;
    do @(posedge clk); while (!req.ready);
  endtask

  initial begin
    rsp.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        rsp.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [lcd_pkg::OP_W-1:0] op;
    lcd_pkg::slot_t           slot;
    int                       pick;
    quiet           = 1'b0;
    rst             <= 1'b1;
    req.valid       <= 1'b0;
    req.operation   <= lcd_pkg::OP_FETCH;
    req.slot_number <= '0;
    req.fill_ok     <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(lcd_pkg::OP_FETCH,      5'd0,  1'b0);
    send_request(lcd_pkg::OP_INVALIDATE, 5'd0,  1'b0);
    send_request(OP_UNUSED,              5'd31, 1'b1);
    send_request(lcd_pkg::OP_FETCH,      5'd31, 1'b1);
    send_request(lcd_pkg::OP_FETCH,      5'd31, 1'b0);
    send_request(lcd_pkg::OP_PUT,        5'd0,  1'b0);
    send_request(lcd_pkg::OP_PUT,        5'd0,  1'b1);
    send_request(lcd_pkg::OP_FETCH,      5'd17, 1'b1);
    send_request(lcd_pkg::OP_FETCH,      5'd9,  1'b1);
    send_request(lcd_pkg::OP_FETCH,      5'd20, 1'b1);
    send_request(lcd_pkg::OP_FETCH,      5'd21, 1'b0);
    send_request(lcd_pkg::OP_PUT,        5'd21, 1'b0);
    send_request(lcd_pkg::OP_INVALIDATE, 5'd31, 1'b1);
    send_request(lcd_pkg::OP_INVALIDATE, 5'd31, 1'b0);
    send_request(lcd_pkg::OP_FETCH,      5'd31, 1'b0);
    send_request(lcd_pkg::OP_PUT,        5'd31, 1'b0);
    send_request(lcd_pkg::OP_FETCH,      5'd10, 1'b1);
    send_request(lcd_pkg::OP_FETCH,      5'd11, 1'b1);
    send_request(lcd_pkg::OP_FETCH,      5'd0,  1'b1);
    send_request(OP_UNUSED,              5'd0,  1'b0);
    send_request(lcd_pkg::OP_INVALIDATE, 5'd10, 1'b0);
    send_request(lcd_pkg::OP_FETCH,      5'd30, 1'b1);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 45) op = lcd_pkg::OP_FETCH;
      else if (pick < 75) op = lcd_pkg::OP_PUT;
      else if (pick < 95) op = lcd_pkg::OP_INVALIDATE;
      else op = OP_UNUSED;
      if ($urandom_range(0, 99) < 85) slot = lcd_pkg::slot_t'($urandom_range(0, 7));
      else slot = lcd_pkg::slot_t'($urandom_range(0, 31));
      send_request(op, slot, $urandom_range(0, 3) != 0);
    end
    req.valid <= 1'b0;
    @(posedge clk);

    guard = 0;
    while (pending != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/lcd_pkg.sv
rtl/core/lcd_if.sv
rtl/core/lcd_victim_sel.sv
rtl/core/lru_cache_directory.sv
rtl/core/lcd_checker.sv
tb/lcd_checker.sv
tb/testbench.sv
